### rtl/core/fspa_pkg.sv
`default_nettype none

package fspa_pkg;

  localparam int unsigned ADDR_BITS    = 32;
  localparam int unsigned SLOT_BYTES_W = 16;
  localparam int unsigned RANGE_W      = 9;
  localparam int unsigned COUNT_W      = 9;
  localparam int unsigned TOTAL_W      = 64;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned BIT_IDX_W    = 5;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 32;

  localparam logic [SLOT_BYTES_W-1:0] SLOT_BYTES_RST = 16'd64;
  localparam logic [RANGE_W-1:0]      POOL_RANGE_RST = 9'd256;
  localparam logic [ADDR_BITS-1:0]    POOL_BASE_RST  = 32'd0;

  typedef enum logic [1:0] {
    REG_SLOT_BYTES = 2'd0,
    REG_POOL_RANGE = 2'd1,
    REG_POOL_BASE  = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [SLOT_BYTES_W-1:0] slot_bytes;
    logic [RANGE_W-1:0]      pool_range;
    logic [ADDR_BITS-1:0]    pool_base;
  } cfg_t;

  typedef struct packed {
    logic in_ready;
    logic row_next;
    logic div_start;
    logic row_from_quot;
    logic grant_slot;
    logic release_slot;
    logic resp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic accept;
    logic is_free;
    logic count_zero;
    logic free_reject;
    logic div_done;
    logic found;
    logic last_row;
    logic free_hit;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/fspa_req_if.sv
`default_nettype none

interface fspa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [fspa_pkg::ADDR_BITS-1:0] address;

  modport source (output valid, command, address, input ready);
  modport sink (input valid, command, address, output ready);
endinterface

`default_nettype wire

### rtl/core/fspa_rsp_if.sv
`default_nettype none

interface fspa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [fspa_pkg::ADDR_BITS-1:0] slot_address;
  logic [fspa_pkg::COUNT_W-1:0]   free_slots;
  logic [fspa_pkg::TOTAL_W-1:0]   bytes_granted_total;
  logic [fspa_pkg::TOTAL_W-1:0]   bytes_released_total;

  modport source (output valid, ok, slot_address, free_slots, bytes_granted_total,
                  bytes_released_total, input ready);
  modport sink (input valid, ok, slot_address, free_slots, bytes_granted_total,
                bytes_released_total, output ready);
endinterface

`default_nettype wire

### rtl/core/fixed_slot_pool_allocator.sv
`default_nettype none

// Fixed-size slot allocator over a slot-usage bitmap held in a RAM of 32-slot words. One request
// is in flight at a time; its result beat sits in an output register, so the next request
// is taken while that beat waits. An allocate scans the bitmap RAM one word per pass up to
// the lowest free slot; a full pool answers without a scan. A free runs the 32-step radix-2
// divider that turns the address offset into a slot index; a free rejected up front skips
// the divider. Writing slots_in_use_range frees every slot at once through per-word valid
// bits; there is no clearing pass. Registers: slot_bytes at 0x0, slots_in_use_range at 0x4,
// pool_base_address at 0x8; write them only while no request is in flight.

module fixed_slot_pool_allocator #(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  fspa_req_if.sink                            req_i,
  fspa_rsp_if.source                          rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fspa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fspa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fspa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned DW = fspa_pkg::APB_DATA_W;

  logic [fspa_pkg::SLOT_BYTES_W-1:0] slot_bytes_q;
  logic [fspa_pkg::RANGE_W-1:0]      pool_range_q;
  logic [fspa_pkg::ADDR_BITS-1:0]    pool_base_q;

  fspa_pkg::reg_idx_e   reg_idx;
  logic                 cfg_we;
  logic                 pool_init;
  fspa_pkg::cfg_t       cfg;
  fspa_pkg::ctrl_cmd_t  cmd;
  fspa_pkg::dp_status_t status;

  assign pready    = 1'b1;
  assign reg_idx   = fspa_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_we    = psel && penable && pwrite && pready;
  assign pool_init = cfg_we && (reg_idx == fspa_pkg::REG_POOL_RANGE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bytes_q <= fspa_pkg::SLOT_BYTES_RST;
      pool_range_q <= fspa_pkg::POOL_RANGE_RST;
      pool_base_q  <= fspa_pkg::POOL_BASE_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        fspa_pkg::REG_SLOT_BYTES: begin
          slot_bytes_q <= pwdata[fspa_pkg::SLOT_BYTES_W-1:0];
        end
        fspa_pkg::REG_POOL_RANGE: begin
          pool_range_q <= pwdata[fspa_pkg::RANGE_W-1:0];
        end
        fspa_pkg::REG_POOL_BASE: begin
          pool_base_q <= pwdata[fspa_pkg::ADDR_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fspa_pkg::REG_SLOT_BYTES: prdata = DW'(slot_bytes_q);
      fspa_pkg::REG_POOL_RANGE: prdata = DW'(pool_range_q);
      fspa_pkg::REG_POOL_BASE:  prdata = DW'(pool_base_q);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.slot_bytes = slot_bytes_q;
  assign cfg.pool_range = pool_range_q;
  assign cfg.pool_base  = pool_base_q;

  fspa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  fspa_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .cfg_i        (cfg),
    .pool_init_i  (pool_init),
    .init_range_i (pwdata[fspa_pkg::RANGE_W-1:0]),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

`default_nettype wire

### rtl/core/fspa_ram.sv
`default_nettype none

module fspa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/fspa_div.sv
`default_nettype none

module fspa_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [fspa_pkg::ADDR_BITS-1:0]    dividend_i,
  input  logic [fspa_pkg::SLOT_BYTES_W-1:0] divisor_i,
  output logic                              done_o,
  output logic [fspa_pkg::ADDR_BITS-1:0]    quotient_o
);

  localparam int unsigned AW    = fspa_pkg::ADDR_BITS;
  localparam int unsigned DW    = fspa_pkg::SLOT_BYTES_W;
  localparam int unsigned CNT_W = $clog2(AW);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q;
  logic [AW-1:0]    quo_q;
  logic [DW-1:0]    dvs_q;
  logic [DW:0]      trial;
  logic             ge;
  logic [DW:0]      diff;

  assign trial = {rem_q, quo_q[AW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(AW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift one quotient bit in per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[AW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

### rtl/core/fspa_dp.sv
`default_nettype none

module fspa_dp #(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fspa_req_if.sink                     req_i,
  fspa_rsp_if.source                   rsp_o,
  input  fspa_pkg::cfg_t               cfg_i,
  input  logic                         pool_init_i,
  input  logic [fspa_pkg::RANGE_W-1:0] init_range_i,
  input  fspa_pkg::ctrl_cmd_t          cmd_i,
  output fspa_pkg::dp_status_t         status_o
);

  localparam int unsigned AW     = fspa_pkg::ADDR_BITS;
  localparam int unsigned SBW    = fspa_pkg::SLOT_BYTES_W;
  localparam int unsigned RW     = fspa_pkg::RANGE_W;
  localparam int unsigned CW     = fspa_pkg::COUNT_W;
  localparam int unsigned TW     = fspa_pkg::TOTAL_W;
  localparam int unsigned WB     = fspa_pkg::WORD_BITS;
  localparam int unsigned BW     = fspa_pkg::BIT_IDX_W;
  localparam int unsigned ROWS   = (POOL_SLOTS + WB - 1) / WB;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SLOT_W = ROW_W + BW;
  localparam int unsigned PROD_W = SLOT_W + SBW;

  function automatic logic [CW-1:0] clamp_size(input logic [RW-1:0] range);
    if (32'(range) > POOL_SLOTS) begin
      return CW'(POOL_SLOTS);
    end
    return CW'(range);
  endfunction

  logic              cmd_q;
  logic [AW-1:0]     addr_q;
  logic [ROW_W-1:0]  row_q;
  logic [AW-1:0]     quot_q;
  logic [SLOT_W-1:0] slot_q;
  logic [PROD_W-1:0] prod_q;
  logic              ok_q;
  logic [ROWS-1:0]   row_valid_q;
  logic [CW-1:0]     count_q;
  logic [TW-1:0]     granted_q;
  logic [TW-1:0]     released_q;
  logic              out_valid_q;
  logic              out_ok_q;
  logic [AW-1:0]     out_addr_q;
  logic [CW-1:0]     out_free_q;
  logic [TW-1:0]     out_granted_q;
  logic [TW-1:0]     out_released_q;

  logic              accept;
  logic [CW-1:0]     active_slots;
  logic [WB-1:0]     ram_rdata;
  logic [WB-1:0]     used_word;
  logic [WB-1:0]     cand;
  logic [BW-1:0]     hit_bit;
  logic              found;
  logic              quot_in_range;
  logic              free_hit;
  logic [AW-1:0]     div_quo;
  logic              div_done;
  logic              div_in_range;
  logic              ram_we;
  logic [WB-1:0]     ram_wdata;
  logic [WB-1:0]     grant_mask;
  logic [WB-1:0]     release_mask;

  assign accept       = req_i.valid && req_i.ready;
  assign req_i.ready  = cmd_i.in_ready;
  assign active_slots = clamp_size(cfg_i.pool_range);

  assign used_word = row_valid_q[row_q] ? ram_rdata : '0;

  always_comb begin
    for (int b = 0; b < WB; b++) begin
      cand[b] = !used_word[b] && (32'({row_q, BW'(b)}) < 32'(active_slots));
    end
  end

  always_comb begin
    hit_bit = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_bit = BW'(b);
      end
    end
  end

  assign found         = |cand;
  assign quot_in_range = quot_q < AW'(active_slots);
  assign free_hit      = quot_in_range && used_word[quot_q[BW-1:0]];
  assign div_in_range  = div_quo < AW'(active_slots);

  assign grant_mask   = WB'(1) << hit_bit;
  assign release_mask = WB'(1) << quot_q[BW-1:0];
  assign ram_we       = cmd_i.grant_slot || cmd_i.release_slot;
  assign ram_wdata    = cmd_i.grant_slot ? (used_word | grant_mask) : (used_word & ~release_mask);

  fspa_ram #(
    .WIDTH (WB),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (ram_wdata),
    .raddr_i (row_q),
    .rdata_o (ram_rdata)
  );

  fspa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (addr_q - cfg_i.pool_base),
    .divisor_i  (cfg_i.slot_bytes),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      count_q     <= clamp_size(fspa_pkg::POOL_RANGE_RST);
      granted_q   <= '0;
      released_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pool_init_i) begin
        row_valid_q <= '0;
        count_q     <= clamp_size(init_range_i);
      end else if (cmd_i.grant_slot) begin
        row_valid_q[row_q] <= 1'b1;
        count_q            <= count_q - 1'b1;
        granted_q          <= granted_q + TW'(cfg_i.slot_bytes);
      end else if (cmd_i.release_slot) begin
        row_valid_q[row_q] <= 1'b1;
        count_q            <= count_q + 1'b1;
        released_q         <= released_q + TW'(cfg_i.slot_bytes);
      end
      if (cmd_i.resp_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(slot_q) * PROD_W'(cfg_i.slot_bytes);
    if (accept) begin
      cmd_q  <= req_i.command;
      addr_q <= req_i.address;
      row_q  <= '0;
      ok_q   <= 1'b0;
    end else if (cmd_i.row_next) begin
      row_q <= row_q + 1'b1;
    end else if (cmd_i.row_from_quot) begin
      quot_q <= div_quo;
      row_q  <= div_in_range ? div_quo[BW +: ROW_W] : '0;
    end
    if (cmd_i.grant_slot) begin
      slot_q <= {row_q, hit_bit};
      ok_q   <= 1'b1;
    end
    if (cmd_i.release_slot) begin
      ok_q <= 1'b1;
    end
    if (cmd_i.resp_load) begin
      out_ok_q       <= ok_q;
      out_addr_q     <= (ok_q && cmd_q == fspa_pkg::CMD_ALLOC) ?
                        cfg_i.pool_base + AW'(prod_q) : '0;
      out_free_q     <= count_q;
      out_granted_q  <= granted_q;
      out_released_q <= released_q;
    end
  end

  assign rsp_o.valid                = out_valid_q;
  assign rsp_o.ok                   = out_ok_q;
  assign rsp_o.slot_address         = out_addr_q;
  assign rsp_o.free_slots           = out_free_q;
  assign rsp_o.bytes_granted_total  = out_granted_q;
  assign rsp_o.bytes_released_total = out_released_q;

  always_comb begin
    status_o.accept      = accept;
    status_o.is_free     = cmd_q == fspa_pkg::CMD_FREE;
    status_o.count_zero  = count_q == '0;
    status_o.free_reject = (addr_q < cfg_i.pool_base) || (cfg_i.slot_bytes == '0);
    status_o.div_done    = div_done;
    status_o.found       = found;
    status_o.last_row    = row_q == ROW_W'(ROWS - 1);
    status_o.free_hit    = free_hit;
    status_o.out_busy    = out_valid_q && !rsp_o.ready;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(active_slots))
    else $error("free slot count above pool size");

  a_grant_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant_slot |-> (count_q != '0) && found)
    else $error("slot granted from an empty pool");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp_load |-> !(out_valid_q && !rsp_o.ready))
    else $error("result beat overwritten before taken");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !cmd_i.in_ready)
    else $error("second request taken while one in flight");
`endif

endmodule

`default_nettype wire

### rtl/core/fspa_ctrl.sv
`default_nettype none

module fspa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fspa_pkg::dp_status_t status_i,
  output fspa_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DECODE    = 9'b000000010,
    S_ALLOC_RD  = 9'b000000100,
    S_ALLOC_CHK = 9'b000001000,
    S_MUL       = 9'b000010000,
    S_DIV       = 9'b000100000,
    S_FREE_RD   = 9'b001000000,
    S_FREE_CHK  = 9'b010000000,
    S_RESP      = 9'b100000000
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.is_free) begin
          if (status_i.free_reject) begin
            state_d = S_RESP;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else if (status_i.count_zero) begin
          state_d = S_RESP;
        end else begin
          state_d = S_ALLOC_RD;
        end
      end
      S_ALLOC_RD: begin
        state_d = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        if (status_i.found) begin
          cmd_o.grant_slot = 1'b1;
          state_d          = S_MUL;
        end else if (status_i.last_row) begin
          state_d = S_RESP;
        end else begin
          cmd_o.row_next = 1'b1;
          state_d        = S_ALLOC_RD;
        end
      end
      S_MUL: begin
        state_d = S_RESP;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.row_from_quot = 1'b1;
          state_d             = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd_o.release_slot = status_i.free_hit;
        state_d            = S_RESP;
      end
      S_RESP: begin
        if (!status_i.out_busy) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
